### hw/rtl/edf_task_scheduler_assert.svh
// assertion macros for the edf task scheduler
`ifndef EDF_TASK_SCHEDULER_ASSERT_SVH
`define EDF_TASK_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
`define EDF_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define EDF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define EDF_ASSERT_IMP(label, clk, rstn, ante, cons)
`define EDF_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

### hw/rtl/edf_pkg.sv
// shared types and constants for the edf task scheduler
`timescale 1ns / 1ps
package edf_pkg;
    localparam int NUM_TASKS = 8;
    localparam int IDX_W     = 3;
    localparam int TIME_W    = 16;
    localparam int CNT_W     = 16;
    localparam int IN_W      = 56;
    localparam int OUT_W     = 48;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_TICK = 2'd1,
        CMD_STAT = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_RUN,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic do_load;
        logic do_stat;
        logic scan_clr;
        logic scan_en;
        logic run;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        cmd_t cmd;
        logic scan_last;
        logic out_full;
    } dp_sts_t;
endpackage

### hw/rtl/edf_ctrl.sv
// sequencing state machine for the edf task scheduler
`timescale 1ns / 1ps
`include "edf_task_scheduler_assert.svh"
module edf_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  edf_pkg::dp_sts_t sts,
    output edf_pkg::dp_cmd_t cmd
);
    import edf_pkg::*;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                // no word is taken while reset is held
                s_tready    = aresetn;
                cmd.capture = s_tvalid && aresetn;
                if (s_tvalid && aresetn) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                case (sts.cmd)
                    CMD_LOAD: begin
                        cmd.do_load = 1'b1;
                        state_next  = ST_OUT;
                    end
                    CMD_TICK: begin
                        cmd.scan_clr = 1'b1;
                        state_next   = ST_SCAN;
                    end
                    CMD_STAT: begin
                        cmd.do_stat = 1'b1;
                        state_next  = ST_OUT;
                    end
                    default: state_next = ST_OUT;
                endcase
            end
            ST_SCAN: begin
                cmd.scan_en = 1'b1;
                if (sts.scan_last) state_next = ST_RUN;
            end
            ST_RUN: begin
                cmd.run    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!sts.out_full) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `EDF_ASSERT_NEXT(a_capture_decode, aclk, aresetn, state_reg == ST_IDLE && s_tvalid, state_reg == ST_DECODE)
    `EDF_ASSERT_NEXT(a_scan_holds, aclk, aresetn, state_reg == ST_SCAN && !sts.scan_last, state_reg == ST_SCAN)
    `EDF_ASSERT_NEXT(a_run_to_out, aclk, aresetn, state_reg == ST_RUN, state_reg == ST_OUT)
endmodule

### hw/rtl/edf_dp.sv
// task table, slot scan and result register of the edf task scheduler
`timescale 1ns / 1ps
module edf_dp (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [edf_pkg::IN_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [edf_pkg::OUT_W-1:0] m_tdata,
    input  edf_pkg::dp_cmd_t         cmd,
    output edf_pkg::dp_sts_t         sts
);
    import edf_pkg::*;

    // captured input word
    cmd_t              in_cmd_reg;
    logic [IDX_W-1:0]  in_idx_reg;
    logic [TIME_W-1:0] in_exe_reg, in_per_reg;
    logic [CNT_W-1:0]  in_cnt_reg;

    // per task state
    logic [TIME_W-1:0] exe_reg  [NUM_TASKS];
    logic [TIME_W-1:0] per_reg  [NUM_TASKS];
    logic [CNT_W-1:0]  jobs_reg [NUM_TASKS];
    logic [TIME_W-1:0] rem_reg  [NUM_TASKS];
    logic [TIME_W-1:0] cd_reg   [NUM_TASKS];
    logic              rdy_reg  [NUM_TASKS];
    logic [CNT_W-1:0]  miss_reg [NUM_TASKS];
    logic [CNT_W-1:0]  comp_reg [NUM_TASKS];

    // scan and selection
    logic [IDX_W-1:0]  scan_reg;
    logic              best_v_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [TIME_W-1:0] best_cd_reg, best_rem_reg;

    // result fields
    logic [IDX_W-1:0]     run_reg;
    logic                 idle_reg, done_reg;
    logic [NUM_TASKS-1:0] mask_reg;
    logic [CNT_W-1:0]     smiss_reg, scomp_reg;

    logic [OUT_W-1:0] m_tdata_reg;
    logic             m_tvalid_reg;

    // slot under scan after expiry and release
    logic              due, miss, rel, n_rdy, better;
    logic [TIME_W-1:0] n_rem, n_cd;
    logic              all_done;

    always_comb begin
        due   = (cd_reg[scan_reg] == '0);
        miss  = due && rdy_reg[scan_reg];
        rel   = due && (jobs_reg[scan_reg] != '0) && (per_reg[scan_reg] != '0);
        n_rdy = rel ? 1'b1 : (miss ? 1'b0 : rdy_reg[scan_reg]);
        n_rem = rel ? exe_reg[scan_reg] : (miss ? '0 : rem_reg[scan_reg]);
        n_cd  = rel ? per_reg[scan_reg] : cd_reg[scan_reg];
        better = n_rdy && (!best_v_reg || (n_cd < best_cd_reg) ||
                 ((n_cd == best_cd_reg) && (n_rem < best_rem_reg)));
    end

    // nothing left to release or run
    always_comb begin
        all_done = 1'b1;
        for (int i = 0; i < NUM_TASKS; i++) begin
            if ((jobs_reg[i] != '0) || rdy_reg[i]) all_done = 1'b0;
        end
    end

    // input capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_cmd_reg <= cmd_t'(s_tdata[1:0]);
            in_idx_reg <= s_tdata[4:2];
            in_exe_reg <= s_tdata[20:5];
            in_per_reg <= s_tdata[36:21];
            in_cnt_reg <= s_tdata[52:37];
        end
    end

    // task table, scan and run
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_TASKS; i++) begin
                exe_reg[i]  <= '0;
                per_reg[i]  <= '0;
                jobs_reg[i] <= '0;
                rem_reg[i]  <= '0;
                cd_reg[i]   <= '0;
                rdy_reg[i]  <= 1'b0;
                miss_reg[i] <= '0;
                comp_reg[i] <= '0;
            end
            scan_reg   <= '0;
            best_v_reg <= 1'b0;
        end else begin
            if (cmd.do_load) begin
                exe_reg[in_idx_reg]  <= (in_exe_reg == '0) ? TIME_W'(1) : in_exe_reg;
                per_reg[in_idx_reg]  <= (in_per_reg == '0) ? TIME_W'(1) : in_per_reg;
                jobs_reg[in_idx_reg] <= in_cnt_reg;
                rem_reg[in_idx_reg]  <= '0;
                cd_reg[in_idx_reg]   <= '0;
                rdy_reg[in_idx_reg]  <= 1'b0;
                miss_reg[in_idx_reg] <= '0;
                comp_reg[in_idx_reg] <= '0;
            end
            if (cmd.scan_clr) begin
                scan_reg   <= '0;
                best_v_reg <= 1'b0;
            end
            if (cmd.scan_en) begin
                scan_reg          <= scan_reg + IDX_W'(1);
                rdy_reg[scan_reg] <= n_rdy;
                rem_reg[scan_reg] <= n_rem;
                cd_reg[scan_reg]  <= n_cd;
                if (miss && (miss_reg[scan_reg] != '1)) begin
                    miss_reg[scan_reg] <= miss_reg[scan_reg] + CNT_W'(1);
                end
                if (rel) jobs_reg[scan_reg] <= jobs_reg[scan_reg] - CNT_W'(1);
                if (better) begin
                    best_v_reg   <= 1'b1;
                    best_idx_reg <= scan_reg;
                    best_cd_reg  <= n_cd;
                    best_rem_reg <= n_rem;
                end
            end
            if (cmd.run) begin
                if (best_v_reg) begin
                    rem_reg[best_idx_reg] <= best_rem_reg - TIME_W'(1);
                    if (best_rem_reg == TIME_W'(1)) begin
                        rdy_reg[best_idx_reg] <= 1'b0;
                        if (comp_reg[best_idx_reg] != '1) begin
                            comp_reg[best_idx_reg] <= comp_reg[best_idx_reg] + CNT_W'(1);
                        end
                    end
                end
                for (int i = 0; i < NUM_TASKS; i++) begin
                    if (cd_reg[i] != '0) cd_reg[i] <= cd_reg[i] - TIME_W'(1);
                end
            end
        end
    end

    // result fields
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            run_reg   <= '0;
            idle_reg  <= 1'b0;
            done_reg  <= 1'b0;
            mask_reg  <= '0;
            smiss_reg <= '0;
            scomp_reg <= '0;
        end
        if (cmd.do_stat) begin
            smiss_reg <= miss_reg[in_idx_reg];
            scomp_reg <= comp_reg[in_idx_reg];
        end
        if (cmd.scan_en && miss) mask_reg[scan_reg] <= 1'b1;
        if (cmd.run) begin
            if (best_v_reg) begin
                run_reg  <= best_idx_reg;
                done_reg <= (best_rem_reg == TIME_W'(1));
            end else begin
                idle_reg <= 1'b1;
            end
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {2'b00, scomp_reg, smiss_reg, all_done, mask_reg,
                            done_reg, idle_reg, run_reg};
        end
    end

    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;
    assign sts.cmd       = in_cmd_reg;
    assign sts.scan_last = (scan_reg == IDX_W'(NUM_TASKS - 1));
    assign sts.out_full  = m_tvalid_reg && !m_tready;
endmodule

### hw/rtl/edf_task_scheduler.sv
// top level of the earliest-deadline-first task scheduler
//
//  channel | dir | handshake           | word
//  s_      | in  | s_tvalid / s_tready | command, task index, exec time, period, job count
//  m_      | out | m_tvalid / m_tready | running task, idle, completion, misses, stats
//
// a load, statistics read or unused command passes through accept, decode and output load
// a tick passes through accept, decode, a scan of the task table at one slot per cycle,
// run and output load
// one word is worked at a time; a waiting result holds the block in its output state
// reset is synchronous, active low, and clears the whole task table
`timescale 1ns / 1ps
module edf_task_scheduler (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // [1:0] command, [4:2] task_index, [20:5] exec_time, [36:21] task_period,
    // [52:37] job_count
    input  logic [edf_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // [2:0] running_task, [3] cpu_idle, [4] job_completed, [12:5] missed_mask,
    // [13] all_done, [29:14] stat_missed, [45:30] stat_completed
    output logic [edf_pkg::OUT_W-1:0] m_tdata
);
    import edf_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencer
    edf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // task table and result path
    edf_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );
endmodule
